>>> rtl/core/vtdc_pkg.sv
// Shared types, Verhoeff tables and codes for the twelve-digit checker.
`timescale 1ns / 1ps

package vtdc_pkg;

    localparam int unsigned CountWidth = 4;
    localparam int unsigned CheckWidth = 4;
    localparam int unsigned CharWidth  = 8;

    typedef enum logic [2:0] {
        REASON_OK       = 3'd0,
        REASON_CHECKSUM = 3'd1,
        REASON_SHORT    = 3'd2,
        REASON_BAD_CHAR = 3'd3,
        REASON_EXTRA    = 3'd4
    } reason_t;

    // Running state of the string currently being checked.
    typedef struct packed {
        logic [CountWidth-1:0] count;
        logic [CheckWidth-1:0] check;
        reason_t               err;
    } chk_state_t;

    // One result, produced when the terminating NUL is processed.
    typedef struct packed {
        logic    fire;
        logic    is_valid;
        reason_t reason;
    } chk_result_t;

    localparam chk_state_t StateReset = '{count: '0, check: '0, err: REASON_OK};

    localparam logic [3:0] D5Mul [10][10] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9},
        '{4'd1, 4'd2, 4'd3, 4'd4, 4'd0, 4'd6, 4'd7, 4'd8, 4'd9, 4'd5},
        '{4'd2, 4'd3, 4'd4, 4'd0, 4'd1, 4'd7, 4'd8, 4'd9, 4'd5, 4'd6},
        '{4'd3, 4'd4, 4'd0, 4'd1, 4'd2, 4'd8, 4'd9, 4'd5, 4'd6, 4'd7},
        '{4'd4, 4'd0, 4'd1, 4'd2, 4'd3, 4'd9, 4'd5, 4'd6, 4'd7, 4'd8},
        '{4'd5, 4'd9, 4'd8, 4'd7, 4'd6, 4'd0, 4'd4, 4'd3, 4'd2, 4'd1},
        '{4'd6, 4'd5, 4'd9, 4'd8, 4'd7, 4'd1, 4'd0, 4'd4, 4'd3, 4'd2},
        '{4'd7, 4'd6, 4'd5, 4'd9, 4'd8, 4'd2, 4'd1, 4'd0, 4'd4, 4'd3},
        '{4'd8, 4'd7, 4'd6, 4'd5, 4'd9, 4'd3, 4'd2, 4'd1, 4'd0, 4'd4},
        '{4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0}
    };

    localparam logic [3:0] D5Perm [8][10] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9},
        '{4'd1, 4'd5, 4'd7, 4'd6, 4'd2, 4'd8, 4'd3, 4'd0, 4'd9, 4'd4},
        '{4'd5, 4'd8, 4'd0, 4'd3, 4'd7, 4'd9, 4'd6, 4'd1, 4'd4, 4'd2},
        '{4'd8, 4'd9, 4'd1, 4'd6, 4'd0, 4'd4, 4'd3, 4'd5, 4'd2, 4'd7},
        '{4'd9, 4'd4, 4'd5, 4'd3, 4'd1, 4'd2, 4'd6, 4'd8, 4'd7, 4'd0},
        '{4'd4, 4'd2, 4'd8, 4'd6, 4'd5, 4'd7, 4'd3, 4'd9, 4'd0, 4'd1},
        '{4'd2, 4'd7, 4'd9, 4'd3, 4'd8, 4'd0, 4'd6, 4'd4, 4'd1, 4'd5},
        '{4'd7, 4'd0, 4'd4, 4'd6, 4'd9, 4'd1, 4'd3, 4'd2, 4'd5, 4'd8}
    };

    // Dihedral group product; operands above nine never occur.
    function automatic logic [3:0] d5_mul(input logic [3:0] a, input logic [3:0] b);
        logic [3:0] r;
        r = 4'd0;
        if (a <= 4'd9 && b <= 4'd9) begin
            r = D5Mul[a][b];
        end
        return r;
    endfunction

    function automatic logic [3:0] d5_perm(input logic [2:0] row, input logic [3:0] dig);
        logic [3:0] r;
        r = 4'd0;
        if (dig <= 4'd9) begin
            r = D5Perm[row][dig];
        end
        return r;
    endfunction

endpackage

>>> rtl/core/verhoeff_twelve_digit_checker.sv
// Top level of the streaming Verhoeff twelve-digit string checker.
// A NUL moves from the input register through the fold step into the output register, where
// its result is shown on m_valid until taken; a full output register holds the NUL back.
// Throughput: one character per cycle while no NUL is held by a full output register.
// Non-NUL characters produce no result; each NUL produces exactly one result transaction.
// Reset (aresetn low, synchronous) empties both registers and clears the check state.
`timescale 1ns / 1ps

module verhoeff_twelve_digit_checker #(
    parameter int unsigned DIGIT_COUNT = 12
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [vtdc_pkg::CharWidth-1:0]      s_char_byte,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_is_valid,
    output logic [2:0]                          m_fail_reason
);
    import vtdc_pkg::*;

    // Input register: holds one accepted character until the fold step takes it.
    logic                 in_valid_reg;
    logic [CharWidth-1:0] char_reg;

    // Running check state of the current string.
    chk_state_t state_reg;
    chk_state_t state_next;

    chk_result_t fold_result;
    logic        slot_free;
    logic        advance;
    logic        load_result;

    // A character that yields no result moves on unconditionally; a NUL waits
    // until the output register can hold its result. This lets a new transaction
    // enter every cycle while a finished result is still waiting downstream, until a NUL is held.
    assign advance     = in_valid_reg && (!fold_result.fire || slot_free);
    assign load_result = advance && fold_result.fire;
    assign s_ready     = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            char_reg <= s_char_byte;
        end
    end

    // The check state only moves when the held character is consumed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= StateReset;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    vtdc_fold #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_fold (
        .char_byte (char_reg),
        .state_cur (state_reg),
        .state_nxt (state_next),
        .result    (fold_result)
    );

    vtdc_result_reg u_result (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (load_result),
        .result        (fold_result),
        .slot_free     (slot_free),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_is_valid    (m_is_valid),
        .m_fail_reason (m_fail_reason)
    );

`ifndef NO_ASSERTIONS
    // The digit counter never runs past the configured digit count.
    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.count <= CountWidth'(DIGIT_COUNT))
        else $error("digit counter exceeded the digit count");

    // The running product stays within the ten group elements.
    a_check_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.check <= 4'd9)
        else $error("running check left the group");

    // Consuming a NUL returns the check state to its reset value.
    a_nul_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        load_result |=> (state_reg == StateReset))
        else $error("state not cleared after end of string");

    // A NUL blocked by a full output register stays in the input register.
    a_nul_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && fold_result.fire && !slot_free) |=>
            (in_valid_reg && $stable(char_reg)))
        else $error("stalled end of string was lost");

    // A passing result never carries a failure code.
    a_valid_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_valid) |-> (m_fail_reason == REASON_OK))
        else $error("valid result with failure reason");
`endif

endmodule

>>> rtl/core/vtdc_fold.sv
// Per-character next-state and result logic of the Verhoeff checker.
`timescale 1ns / 1ps

module vtdc_fold #(
    parameter int unsigned DIGIT_COUNT = 12
) (
    input  logic [vtdc_pkg::CharWidth-1:0] char_byte,
    input  vtdc_pkg::chk_state_t           state_cur,
    output vtdc_pkg::chk_state_t           state_nxt,
    output vtdc_pkg::chk_result_t          result
);
    import vtdc_pkg::*;

    localparam logic [CountWidth-1:0] CountFull = CountWidth'(DIGIT_COUNT);
    localparam logic [CountWidth-1:0] CountLast = CountWidth'(DIGIT_COUNT - 1);

    logic       is_nul;
    logic       is_blank;
    logic       is_digit;
    logic       full;
    logic [2:0] row;
    logic [3:0] term;

    assign is_nul   = (char_byte == 8'd0);
    assign is_blank = (char_byte == 8'd32) || (char_byte >= 8'd9 && char_byte <= 8'd13);
    assign is_digit = (char_byte >= 8'd48) && (char_byte <= 8'd57);
    assign full     = (state_cur.count >= CountFull);
    // Digit k from the left uses permutation row (N-1-k) mod 8.
    assign row      = 3'(CountLast - state_cur.count);
    assign term     = d5_perm(row, char_byte[3:0]);

    always_comb begin
        result.fire     = is_nul;
        result.is_valid = 1'b0;
        result.reason   = REASON_OK;
        if (state_cur.err != REASON_OK) begin
            result.reason = state_cur.err;
        end else if (!full) begin
            result.reason = REASON_SHORT;
        end else if (state_cur.check != 4'd0) begin
            result.reason = REASON_CHECKSUM;
        end
        result.is_valid = (result.reason == REASON_OK);

        state_nxt = state_cur;
        if (is_nul) begin
            state_nxt = StateReset;
        end else if (state_cur.err != REASON_OK) begin
            state_nxt = state_cur;
        end else if (full) begin
            state_nxt.err = REASON_EXTRA;
        end else if (is_blank) begin
            state_nxt = state_cur;
        end else if (is_digit) begin
            state_nxt.check = d5_mul(term, state_cur.check);
            state_nxt.count = state_cur.count + 1'b1;
        end else begin
            state_nxt.err = REASON_BAD_CHAR;
        end
    end

endmodule

>>> rtl/core/vtdc_result_reg.sv
// Output register of the Verhoeff checker with valid/ready handshake.
`timescale 1ns / 1ps

module vtdc_result_reg (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  vtdc_pkg::chk_result_t result,
    output logic                  slot_free,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_is_valid,
    output logic [2:0]            m_fail_reason
);
    import vtdc_pkg::*;

    logic    valid_reg;
    logic    is_valid_reg;
    reason_t reason_reg;

    // The slot can take a new result when empty or being drained this cycle.
    assign slot_free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            is_valid_reg <= result.is_valid;
            reason_reg   <= result.reason;
        end
    end

    assign m_valid       = valid_reg;
    assign m_is_valid    = is_valid_reg;
    assign m_fail_reason = reason_reg;

endmodule
